/* hw/rtl/c3r_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3r_pkg
// Shared types and constants of the 3x3 convolution / ReLU unit.
// ----------------------------------------------------------------------------
package c3r_pkg;

    localparam int TAPS     = 9;
    localparam int KSIZE    = 3;
    localparam int RELU_MAX = 127;
    localparam int SUM_W    = 20;
    localparam int NPOS     = 4;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_PIXEL  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_EMIT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic       wr_weight;
        logic       load_pix;
        logic       shift;
        logic       issue;
        logic [1:0] issue_pos;
        logic [3:0] issue_ch;
        logic       issue_last;
        logic       advance;
    } t_ctrl_cmd;

    typedef struct packed {
        logic            pipe_en;
        logic            busy;
        logic [NPOS-1:0] pos_flags;
    } t_ctrl_status;

endpackage
`default_nettype wire

/* hw/rtl/c3r_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3r_in_if / c3r_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface c3r_in_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [7:0] pixel_value;
    logic        [3:0] weight_channel;
    logic        [3:0] weight_tap;
    logic signed [7:0] weight_value;

    modport source (
        output valid, cmd, pixel_value, weight_channel, weight_tap, weight_value,
        input  ready
    );
    modport sink (
        input  valid, cmd, pixel_value, weight_channel, weight_tap, weight_value,
        output ready
    );
endinterface

interface c3r_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] out_row;
    logic [4:0] out_col;
    logic [3:0] out_channel;
    logic [6:0] out_value;
    logic       last_of_run;

    modport source (
        output valid, out_row, out_col, out_channel, out_value, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_row, out_col, out_channel, out_value, last_of_run,
        output ready
    );
endinterface
`default_nettype wire

/* hw/rtl/c3r_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3r_ctrl
// Sequencer: takes items, steps through output positions and channels.
// ----------------------------------------------------------------------------
module c3r_ctrl #(
    parameter int OUT_CHANNELS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire                      i_in_cmd,
    output logic                     o_in_ready,
    input  c3r_pkg::t_ctrl_status    i_status,
    output c3r_pkg::t_ctrl_cmd       o_cmd
);

    localparam int CHW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;

    c3r_pkg::t_state r_state, n_state;
    logic [1:0]      r_pos, n_pos;
    logic [CHW-1:0]  r_ch, n_ch;

    logic [c3r_pkg::NPOS-1:0] above;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= c3r_pkg::ST_IDLE;
            r_pos   <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_ch    <= n_ch;
        end
    end

    assign above = (i_status.pos_flags >> r_pos) >> 1;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_ch       = r_ch;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            c3r_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == c3r_pkg::CMD_PIXEL) begin
                        o_cmd.load_pix = 1'b1;
                        n_state        = c3r_pkg::ST_SHIFT;
                    end else begin
                        o_cmd.wr_weight = 1'b1;
                    end
                end
            end
            c3r_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_pos       = '0;
                n_ch        = '0;
                n_state     = c3r_pkg::ST_EMIT;
            end
            c3r_pkg::ST_EMIT: begin
                if (!i_status.pos_flags[r_pos]) begin
                    n_pos = r_pos + 2'd1;
                    if (r_pos == 2'(c3r_pkg::NPOS - 1)) begin
                        n_state = c3r_pkg::ST_DRAIN;
                    end
                end else if (i_status.pipe_en) begin
                    o_cmd.issue      = 1'b1;
                    o_cmd.issue_pos  = r_pos;
                    o_cmd.issue_ch   = 4'(r_ch);
                    o_cmd.issue_last = (r_ch == CHW'(OUT_CHANNELS - 1)) && (above == '0);
                    if (r_ch == CHW'(OUT_CHANNELS - 1)) begin
                        n_ch  = '0;
                        n_pos = r_pos + 2'd1;
                        if (r_pos == 2'(c3r_pkg::NPOS - 1)) begin
                            n_state = c3r_pkg::ST_DRAIN;
                        end
                    end else begin
                        n_ch = r_ch + 1'b1;
                    end
                end
            end
            c3r_pkg::ST_DRAIN: begin
                if (!i_status.busy) begin
                    o_cmd.advance = 1'b1;
                    n_state       = c3r_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = c3r_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hw/rtl/c3r_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c3r_datapath
// Weight memory, line memory, 3x3 window, position counters and the
// read / multiply / sum-and-clamp pipeline with its output register.
// ----------------------------------------------------------------------------
module c3r_datapath #(
    parameter int IMG_HEIGHT   = 32,
    parameter int IMG_WIDTH    = 32,
    parameter int OUT_CHANNELS = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  c3r_pkg::t_ctrl_cmd       i_cmd,
    output c3r_pkg::t_ctrl_status    o_status,
    input  wire signed [7:0]         i_pixel,
    input  wire        [3:0]         i_wch,
    input  wire        [3:0]         i_wtap,
    input  wire signed [7:0]         i_wval,
    output logic                     o_valid,
    input  wire                      i_ready,
    output logic       [4:0]         o_row,
    output logic       [4:0]         o_col,
    output logic       [3:0]         o_ch,
    output logic       [6:0]         o_value,
    output logic                     o_last
);

    localparam int CHW = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
    localparam int RW  = $clog2(IMG_HEIGHT);
    localparam int CW  = $clog2(IMG_WIDTH);
    localparam int RXW = RW + 5;
    localparam int CXW = CW + 5;
    localparam int SW  = c3r_pkg::SUM_W;

    // memories
    logic signed [7:0]  r_wmem [OUT_CHANNELS][c3r_pkg::TAPS];
    logic        [15:0] r_line [IMG_WIDTH];
    logic        [15:0] r_line_q;
    logic signed [7:0]  r_pix;

    logic signed [7:0]  r_win [c3r_pkg::KSIZE][c3r_pkg::KSIZE];
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;

    // read stage
    logic               r_rd_v;
    logic [1:0]         r_rd_pos;
    logic [3:0]         r_rd_ch;
    logic               r_rd_last;
    logic signed [7:0]  r_wrow [c3r_pkg::TAPS];

    // multiply stage
    logic               r_mul_v;
    logic signed [15:0] r_prod [c3r_pkg::TAPS];
    logic [4:0]         r_mul_row;
    logic [4:0]         r_mul_col;
    logic [3:0]         r_mul_ch;
    logic               r_mul_last;

    // output register
    logic               r_out_v;
    logic [4:0]         r_out_row;
    logic [4:0]         r_out_col;
    logic [3:0]         r_out_ch;
    logic [6:0]         r_out_val;
    logic               r_out_last;

    logic               pipe_en;
    logic [RW-1:0]      orow;
    logic [CW-1:0]      ocol;
    logic [RXW-1:0]     orow_x;
    logic [CXW-1:0]     ocol_x;
    logic [2:0]         rv;
    logic [2:0]         cv;
    logic signed [15:0] n_prod [c3r_pkg::TAPS];
    logic signed [SW-1:0] sum;
    logic [6:0]         n_val;
    logic [RW-1:0]      n_row;
    logic [CW-1:0]      n_col;

    assign pipe_en = !r_out_v || i_ready;

    assign o_status.pipe_en      = pipe_en;
    assign o_status.busy         = r_rd_v | r_mul_v;
    assign o_status.pos_flags[0] = (r_row != '0) && (r_col != '0);
    assign o_status.pos_flags[1] = (r_row != '0) && (r_col == CW'(IMG_WIDTH - 1));
    assign o_status.pos_flags[2] = (r_row == RW'(IMG_HEIGHT - 1)) && (r_col != '0);
    assign o_status.pos_flags[3] = (r_row == RW'(IMG_HEIGHT - 1)) &&
                                   (r_col == CW'(IMG_WIDTH - 1));

    // weight memory: byte-lane write, row read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_weight && (int'(i_wch) < OUT_CHANNELS) &&
            (int'(i_wtap) < c3r_pkg::TAPS)) begin
            r_wmem[i_wch[CHW-1:0]][i_wtap] <= i_wval;
        end
        if (pipe_en) begin
            r_wrow <= r_wmem[i_cmd.issue_ch[CHW-1:0]];
        end
    end

    // line memory: {older row, newer row} per column
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pix) begin
            r_line_q <= r_line[r_col];
            r_pix    <= i_pixel;
        end
        if (i_cmd.shift) begin
            r_line[r_col] <= {r_line_q[7:0], r_pix};
        end
    end

    // window and position
    always_comb begin
        n_row = r_row;
        n_col = r_col + 1'b1;
        if (r_col == CW'(IMG_WIDTH - 1)) begin
            n_col = '0;
            n_row = (r_row == RW'(IMG_HEIGHT - 1)) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '{default: '0};
            r_row <= '0;
            r_col <= '0;
        end else begin
            if (i_cmd.shift) begin
                for (int i = 0; i < c3r_pkg::KSIZE; i++) begin
                    r_win[i][0] <= r_win[i][1];
                    r_win[i][1] <= r_win[i][2];
                end
                r_win[0][2] <= r_line_q[15:8];
                r_win[1][2] <= r_line_q[7:0];
                r_win[2][2] <= r_pix;
            end
            if (i_cmd.advance) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

    // tap selection and products
    always_comb begin
        int wr;
        int wc;
        logic signed [7:0] px;
        orow   = r_rd_pos[1] ? RW'(IMG_HEIGHT - 1) : r_row - 1'b1;
        ocol   = r_rd_pos[0] ? CW'(IMG_WIDTH - 1) : r_col - 1'b1;
        orow_x = RXW'(orow);
        ocol_x = CXW'(ocol);
        rv     = {orow != RW'(IMG_HEIGHT - 1), 1'b1, orow != '0};
        cv     = {ocol != CW'(IMG_WIDTH - 1), 1'b1, ocol != '0};
        for (int ki = 0; ki < c3r_pkg::KSIZE; ki++) begin
            for (int kj = 0; kj < c3r_pkg::KSIZE; kj++) begin
                wr = ki + int'(r_rd_pos[1]);
                wc = kj + int'(r_rd_pos[0]);
                if (wr > 2) wr = 2;
                if (wc > 2) wc = 2;
                px = (rv[ki] && cv[kj]) ? r_win[2'(wr)][2'(wc)] : 8'sd0;
                n_prod[ki*c3r_pkg::KSIZE+kj] = 16'(px) * 16'(r_wrow[ki*c3r_pkg::KSIZE+kj]);
            end
        end
    end

    // sum and clamp
    always_comb begin
        sum = '0;
        for (int t = 0; t < c3r_pkg::TAPS; t++) begin
            sum = sum + SW'(r_prod[t]);
        end
        if (sum > SW'(c3r_pkg::RELU_MAX)) begin
            n_val = 7'(c3r_pkg::RELU_MAX);
        end else if (sum < 0) begin
            n_val = '0;
        end else begin
            n_val = sum[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (pipe_en) begin
            r_rd_v  <= i_cmd.issue;
            r_mul_v <= r_rd_v;
            r_out_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_rd_pos   <= i_cmd.issue_pos;
            r_rd_ch    <= i_cmd.issue_ch;
            r_rd_last  <= i_cmd.issue_last;
            r_prod     <= n_prod;
            r_mul_row  <= orow_x[4:0];
            r_mul_col  <= ocol_x[4:0];
            r_mul_ch   <= r_rd_ch;
            r_mul_last <= r_rd_last;
            r_out_row  <= r_mul_row;
            r_out_col  <= r_mul_col;
            r_out_ch   <= r_mul_ch;
            r_out_val  <= n_val;
            r_out_last <= r_mul_last;
        end
    end

    assign o_valid = r_out_v;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_ch    = r_out_ch;
    assign o_value = r_out_val;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

/* hw/rtl/conv3x3_relu_multichannel_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Weight load: one item per cycle while idle. Pixel: shifted into the window, then P =
// output positions it completes (0 to 4) are issued one channel per cycle, held while
// the output stalls, into the nine-multiplier pipeline; no new item is taken meanwhile.
// Reset clears the sequencer, the window, the row/column position and the output
// register; weights are undefined until loaded, and no clearing pass runs.
// ----------------------------------------------------------------------------
// conv3x3_relu_multichannel_unit
// 3x3 same-padded convolution with saturating ReLU over several output channels.
// ----------------------------------------------------------------------------
module conv3x3_relu_multichannel_unit #(
    parameter int IMG_HEIGHT   = 32,
    parameter int IMG_WIDTH    = 32,
    parameter int OUT_CHANNELS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    c3r_in_if.sink     i_in,
    c3r_out_if.source  o_out
);

    c3r_pkg::t_ctrl_cmd    cmd;
    c3r_pkg::t_ctrl_status status;

    c3r_ctrl #(
        .OUT_CHANNELS (OUT_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    c3r_datapath #(
        .IMG_HEIGHT   (IMG_HEIGHT),
        .IMG_WIDTH    (IMG_WIDTH),
        .OUT_CHANNELS (OUT_CHANNELS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_pixel  (i_in.pixel_value),
        .i_wch    (i_in.weight_channel),
        .i_wtap   (i_in.weight_tap),
        .i_wval   (i_in.weight_value),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_row    (o_out.out_row),
        .o_col    (o_out.out_col),
        .o_ch     (o_out.out_channel),
        .o_value  (o_out.out_value),
        .o_last   (o_out.last_of_run)
    );

endmodule
`default_nettype wire

/* sim/tb_conv3x3_relu_multichannel_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_conv3x3_relu_multichannel_unit
// Self-checking bench for the 3x3 convolution / ReLU unit. It loads every
// kernel weight, streams pixels in raster order through the first rows of a
// frame, and mixes in weight reloads. The input side sends in random bursts
// with gaps, and the output side stalls on its own pattern. Every result is
// compared with an in-bench model of the convolution, the clamp and the
// emission order.
// ----------------------------------------------------------------------------
module tb_conv3x3_relu_multichannel_unit;

    localparam int IMG_H        = 32;
    localparam int IMG_W        = 32;
    localparam int N_CH         = 16;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_LEN     = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic              cmd;
        logic signed [7:0] pix;
        logic        [3:0] wch;
        logic        [3:0] wtap;
        logic signed [7:0] wval;
    } t_conv_item;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        logic [3:0] ch;
        logic [6:0] value;
        logic       last;
    } t_fmap_result;

    logic i_clk;
    logic i_rst_n;

    c3r_in_if  in_ch ();
    c3r_out_if out_ch ();

    conv3x3_relu_multichannel_unit #(
        .IMG_HEIGHT   (IMG_H),
        .IMG_WIDTH    (IMG_W),
        .OUT_CHANNELS (N_CH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_conv_item   item_q [$];
    t_fmap_result fmap_q [$];
    t_conv_item   drv_item;

    logic signed [7:0] kern_mem [0:N_CH-1][0:c3r_pkg::TAPS-1];
    logic signed [7:0] row_buf  [0:1][0:IMG_W-1];
    logic signed [7:0] nbhd     [0:c3r_pkg::KSIZE-1][0:c3r_pkg::KSIZE-1];
    int next_row = 0;
    int next_col = 0;

    int mismatches    = 0;
    int results_seen  = 0;
    int pixels_queued = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int rx_cyc        = 0;
    int rx_phase      = 0;
    int stall_period  = 4;
    int stall_duty    = 1;

    initial begin
        i_clk                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.cmd            = c3r_pkg::CMD_PIXEL;
        in_ch.pixel_value    = '0;
        in_ch.weight_channel = '0;
        in_ch.weight_tap     = '0;
        in_ch.weight_value   = '0;
        out_ch.ready         = 1'b0;
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < IMG_W; j++)
                row_buf[i][j] = '0;
        for (int i = 0; i < c3r_pkg::KSIZE; i++)
            for (int j = 0; j < c3r_pkg::KSIZE; j++)
                nbhd[i][j] = '0;
        for (int i = 0; i < N_CH; i++)
            for (int j = 0; j < c3r_pkg::TAPS; j++)
                kern_mem[i][j] = '0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #36_000_000;
        $display("conv3x3_relu_multichannel_unit regression: fail");
        $finish;
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH: %s", msg);
    endtask

    // one output position: all channels, clamped to 0..RELU_MAX
    task automatic conv_position(input int orow, input int ocol, input int r, input int c);
        int sum;
        int ir;
        int ic;
        int wr;
        int wc;
        t_fmap_result res;
        for (int ch = 0; ch < N_CH; ch++) begin
            sum = 0;
            for (int ki = 0; ki < c3r_pkg::KSIZE; ki++) begin
                for (int kj = 0; kj < c3r_pkg::KSIZE; kj++) begin
                    ir = orow - 1 + ki;
                    ic = ocol - 1 + kj;
                    wr = ir - (r - 2);
                    wc = ic - (c - 2);
                    if (ir >= 0 && ir < IMG_H && ic >= 0 && ic < IMG_W &&
                        wr >= 0 && wr < c3r_pkg::KSIZE && wc >= 0 && wc < c3r_pkg::KSIZE)
                        sum += int'(nbhd[wr][wc]) *
                               int'(kern_mem[ch][ki * c3r_pkg::KSIZE + kj]);
                end
            end
            if (sum > c3r_pkg::RELU_MAX)
                sum = c3r_pkg::RELU_MAX;
            else if (sum < 0)
                sum = 0;
            res.row   = 5'(orow);
            res.col   = 5'(ocol);
            res.ch    = 4'(ch);
            res.value = 7'(sum);
            res.last  = 1'b0;
            fmap_q.push_back(res);
        end
    endtask

    task automatic conv_pixel(input logic signed [7:0] pix);
        int r;
        int c;
        int n0;
        r  = next_row;
        c  = next_col;
        n0 = fmap_q.size();
        for (int i = 0; i < c3r_pkg::KSIZE; i++) begin
            nbhd[i][0] = nbhd[i][1];
            nbhd[i][1] = nbhd[i][2];
        end
        nbhd[0][2] = row_buf[0][c];
        nbhd[1][2] = row_buf[1][c];
        nbhd[2][2] = pix;
        row_buf[0][c] = row_buf[1][c];
        row_buf[1][c] = pix;
        if (r >= 1) begin
            if (c >= 1)
                conv_position(r - 1, c - 1, r, c);
            if (c == IMG_W - 1)
                conv_position(r - 1, IMG_W - 1, r, c);
            if (r == IMG_H - 1) begin
                if (c >= 1)
                    conv_position(IMG_H - 1, c - 1, r, c);
                if (c == IMG_W - 1)
                    conv_position(IMG_H - 1, IMG_W - 1, r, c);
            end
        end
        if (fmap_q.size() > n0)
            fmap_q[fmap_q.size() - 1].last = 1'b1;
        c++;
        if (c >= IMG_W) begin
            c = 0;
            r++;
            if (r >= IMG_H)
                r = 0;
        end
        next_row = r;
        next_col = c;
    endtask

    function automatic logic signed [7:0] rand_weight();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom);
        return 8'(int'($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic signed [7:0] rand_pixel();
        if ($urandom_range(0, 4) < 2)
            return 8'($urandom);
        return 8'(int'($urandom_range(0, 32)) - 16);
    endfunction

    task automatic queue_weight(input int ch, input int tap, input logic signed [7:0] val);
        t_conv_item it;
        it.cmd  = c3r_pkg::CMD_WEIGHT;
        it.pix  = 8'($urandom);
        it.wch  = 4'(ch);
        it.wtap = 4'(tap);
        it.wval = val;
        item_q.push_back(it);
    endtask

    task automatic queue_pixel(input logic signed [7:0] val);
        t_conv_item it;
        it.cmd  = c3r_pkg::CMD_PIXEL;
        it.pix  = val;
        it.wch  = 4'($urandom);
        it.wtap = 4'($urandom);
        it.wval = 8'($urandom);
        item_q.push_back(it);
        pixels_queued++;
    endtask

    task automatic queue_random();
        int tap;
        if ($urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 7) == 0)
                tap = $urandom_range(c3r_pkg::TAPS, 15);
            else
                tap = $urandom_range(0, c3r_pkg::TAPS - 1);
            queue_weight($urandom_range(0, N_CH - 1), tap, rand_weight());
        end else begin
            queue_pixel(rand_pixel());
        end
    endtask

    // wait until every queued item is taken and every result has arrived
    task automatic drain();
        while (item_q.size() != 0 || in_ch.valid || fmap_q.size() != 0)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                if (in_ch.cmd == c3r_pkg::CMD_WEIGHT) begin
                    if (in_ch.weight_tap < c3r_pkg::TAPS)
                        kern_mem[in_ch.weight_channel][in_ch.weight_tap] = in_ch.weight_value;
                end else begin
                    conv_pixel(in_ch.pixel_value);
                end
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0 || item_q.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    in_ch.valid <= 1'b0;
                end else begin
                    drv_item = item_q.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.cmd            <= drv_item.cmd;
                    in_ch.pixel_value    <= drv_item.pix;
                    in_ch.weight_channel <= drv_item.wch;
                    in_ch.weight_tap     <= drv_item.wtap;
                    in_ch.weight_value   <= drv_item.wval;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    task automatic take_result();
        t_fmap_result want;
        results_seen++;
        if (fmap_q.size() == 0) begin
            report($sformatf("unexpected result row %0d col %0d ch %0d value %0d last %0b",
                             out_ch.out_row, out_ch.out_col, out_ch.out_channel,
                             out_ch.out_value, out_ch.last_of_run));
        end else begin
            want = fmap_q.pop_front();
            if (out_ch.out_row !== want.row || out_ch.out_col !== want.col ||
                out_ch.out_channel !== want.ch || out_ch.out_value !== want.value ||
                out_ch.last_of_run !== want.last)
                report($sformatf({"got row %0d col %0d ch %0d value %0d last %0b, ",
                                  "expected row %0d col %0d ch %0d value %0d last %0b"},
                                 out_ch.out_row, out_ch.out_col, out_ch.out_channel,
                                 out_ch.out_value, out_ch.last_of_run, want.row, want.col,
                                 want.ch, want.value, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                take_result();
            rx_cyc++;
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else begin
                if (rx_cyc % 200 == 0) begin
                    stall_period = $urandom_range(2, 8);
                    stall_duty   = ($urandom_range(0, 3) == 0) ? 0 :
                                   $urandom_range(1, stall_period - 1);
                    rx_phase     = 0;
                end
                out_ch.ready <= (rx_phase >= stall_duty);
                rx_phase = (rx_phase + 1) % stall_period;
            end
        end
    end

    initial begin
        logic signed [7:0] corner_pix [0:19];
        logic signed [7:0] wv;
        corner_pix = '{127, -128, 0, 1, -1, 127, 127, 127, -128, -128,
                       -128, 64, -64, 2, -2, 100, -100, 0, 127, -128};
        @(posedge i_rst_n);
        // full positive, full negative, identity kernel, then random ones
        for (int ch = 0; ch < N_CH; ch++) begin
            for (int t = 0; t < c3r_pkg::TAPS; t++) begin
                if (ch == 0)
                    wv = 8'sd127;
                else if (ch == 1)
                    wv = -8'sd128;
                else if (ch == 2)
                    wv = (t == 4) ? 8'sd1 : 8'sd0;
                else
                    wv = rand_weight();
                queue_weight(ch, t, wv);
            end
        end
        queue_weight(5, c3r_pkg::TAPS, rand_weight());
        queue_weight(N_CH - 1, 15, rand_weight());
        for (int i = 0; i < 20; i++)
            queue_pixel(corner_pix[i]);
        drain();
        while (pixels_queued < 100)
            queue_random();
        drain();
        // run on through the next rows, with the long output hold behind
        while (pixels_queued < 175)
            queue_random();
        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fmap_q.size() != 0)
            report($sformatf("%0d results never arrived", fmap_q.size()));
        if (mismatches == 0) begin
            $display("conv3x3_relu_multichannel_unit regression: pass");
        end else begin
            $display("conv3x3_relu_multichannel_unit regression: fail");
        end
        $finish;
    end

endmodule
